// File: rtl/gsr_pkg.sv
// Shared types, codes and helpers for the ghost cell reflection pipeline.
package gsr_pkg;

    localparam int DATA_W         = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ADDR_W         = 5;
    localparam int IN_TDATA_W     = 296;
    localparam int OUT_TDATA_W    = 192;

    localparam logic [2:0] KIND_WALL   = 3'd0;
    localparam logic [2:0] KIND_SYM3D  = 3'd1;
    localparam logic [2:0] KIND_SYM2D  = 3'd2;
    localparam logic [2:0] KIND_EXTRAP = 3'd3;
    localparam logic [2:0] KIND_FREE   = 3'd4;

    localparam logic [3:0] NEG_LAYER = 4'd3;

    localparam logic [2:0] REG_FREE_DENSITY     = 3'd0;
    localparam logic [2:0] REG_FREE_VEL_X       = 3'd1;
    localparam logic [2:0] REG_FREE_VEL_Y       = 3'd2;
    localparam logic [2:0] REG_FREE_VEL_Z       = 3'd3;
    localparam logic [2:0] REG_FREE_PRESSURE    = 3'd4;
    localparam logic [2:0] REG_FREE_TEMPERATURE = 3'd5;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         layer;
        logic signed [31:0] metric_x;
        logic signed [31:0] metric_y;
        logic signed [31:0] metric_z;
        logic signed [31:0] cell_density;
        logic signed [31:0] cell_vel_x;
        logic signed [31:0] cell_vel_y;
        logic signed [31:0] cell_vel_z;
        logic signed [31:0] cell_pressure;
        logic signed [31:0] cell_temperature;
    } side_t;

    // Clamp a 40-bit signed value to the 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end
        else if (x < -40'sd2147483648) begin
            r = 32'sh80000000;
        end
        else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/gsr_sqrt.sv
// Squared metric length and pipelined integer square root, one root bit per stage.
module gsr_sqrt
    import gsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  side_t       in_side,
    output logic        out_valid,
    input  logic        out_ready,
    output side_t       out_side,
    output logic [31:0] out_root
);

    localparam int STEPS = 32;
    localparam int N     = STEPS + 2;

    logic [N-1:0] valid_reg;
    logic [N-1:0] en;
    side_t        side_reg [N];
    logic [63:0]  sq_reg [3];
    logic [63:0]  sum_reg;
    logic [33:0]  rem_reg  [STEPS];
    logic [31:0]  root_reg [STEPS];
    logic [63:0]  sh_reg   [STEPS];
    logic [33:0]  rem_next  [STEPS];
    logic [31:0]  root_next [STEPS];
    logic [63:0]  sh_next   [STEPS];
    logic [63:0]  sq_next [3];

    // Stall chain: a stage loads when empty or when its successor loads.
    always_comb
    begin
        en[N-1] = !valid_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    // Full 64-bit squares of the signed metric components.
    always_comb
    begin
        logic signed [63:0] p [3];
        p[0] = in_side.metric_x * in_side.metric_x;
        p[1] = in_side.metric_y * in_side.metric_y;
        p[2] = in_side.metric_z * in_side.metric_z;
        for (int c = 0; c < 3; c++) begin
            sq_next[c] = $unsigned(p[c]);
        end
    end

    always_comb
    begin
        logic [33:0] rem_p;
        logic [31:0] root_p;
        logic [63:0] sh_p;
        logic [34:0] t;
        logic [34:0] trial;
        for (int j = 0; j < STEPS; j++) begin
            if (j == 0) begin
                rem_p  = '0;
                root_p = '0;
                sh_p   = sum_reg;
            end
            else begin
                rem_p  = rem_reg[j-1];
                root_p = root_reg[j-1];
                sh_p   = sh_reg[j-1];
            end
            t     = {rem_p[32:0], sh_p[63:62]};
            trial = {1'b0, root_p, 2'b01};
            if (t >= trial) begin
                rem_next[j]  = 34'(t - trial);
                root_next[j] = {root_p[30:0], 1'b1};
            end
            else begin
                rem_next[j]  = t[33:0];
                root_next[j] = {root_p[30:0], 1'b0};
            end
            sh_next[j] = {sh_p[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            for (int k = 0; k < N; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            side_reg[0] <= in_side;
            for (int c = 0; c < 3; c++) begin
                sq_reg[c] <= sq_next[c];
            end
        end
        if (en[1]) begin
            side_reg[1] <= side_reg[0];
            sum_reg     <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
        for (int j = 0; j < STEPS; j++) begin
            if (en[j+2]) begin
                side_reg[j+2] <= side_reg[j+1];
                rem_reg[j]    <= rem_next[j];
                root_reg[j]   <= root_next[j];
                sh_reg[j]     <= sh_next[j];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_root  = root_reg[STEPS-1];

endmodule

// File: rtl/gsr_div.sv
// Pipelined restoring divider forming the unit normal, one quotient bit per stage.
module gsr_div
    import gsr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  side_t                     in_side,
    input  logic [31:0]               in_root,
    output logic                      out_valid,
    input  logic                      out_ready,
    output side_t                     out_side,
    output logic signed [FRAC_BITS+1:0] out_norm [3]
);

    localparam int QW    = FRAC_BITS + 1;
    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int N     = QW + 2;

    logic [N-1:0] valid_reg;
    logic [N-1:0] en;
    side_t        side_reg [N];
    logic [31:0]  len_reg  [N-1];
    logic [2:0]   neg_reg  [N-1];
    logic [31:0]  mag_reg  [3];
    logic [31:0]  rem_reg  [QW][3];
    logic [QW-1:0] lo_reg  [QW][3];
    logic [QW-1:0] q_reg   [QW][3];
    logic [31:0]  rem_next [QW][3];
    logic [QW-1:0] lo_next [QW][3];
    logic [QW-1:0] q_next  [QW][3];
    logic signed [FRAC_BITS+1:0] norm_reg [3];
    logic signed [31:0] m_in [3];

    always_comb
    begin
        en[N-1] = !valid_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        m_in[0] = in_side.metric_x;
        m_in[1] = in_side.metric_y;
        m_in[2] = in_side.metric_z;
    end

    always_comb
    begin
        logic [31:0]    rem_p;
        logic [QW-1:0]  lo_p;
        logic [QW-1:0]  q_p;
        logic [NUM_W-1:0] num;
        logic [32:0]    t;
        for (int j = 0; j < QW; j++) begin
            for (int c = 0; c < 3; c++) begin
                if (j == 0) begin
                    num   = {mag_reg[c], {FRAC_BITS{1'b0}}};
                    rem_p = 32'(num[NUM_W-1:QW]);
                    lo_p  = num[QW-1:0];
                    q_p   = '0;
                end
                else begin
                    rem_p = rem_reg[j-1][c];
                    lo_p  = lo_reg[j-1][c];
                    q_p   = q_reg[j-1][c];
                end
                t = {rem_p, lo_p[QW-1]};
                if (t >= {1'b0, len_reg[j]}) begin
                    rem_next[j][c] = 32'(t - {1'b0, len_reg[j]});
                    q_next[j][c]   = {q_p[QW-2:0], 1'b1};
                end
                else begin
                    rem_next[j][c] = t[31:0];
                    q_next[j][c]   = {q_p[QW-2:0], 1'b0};
                end
                lo_next[j][c] = {lo_p[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            for (int k = 0; k < N; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // Floor the length at one LSB, split the metric into sign and magnitude.
        if (en[0]) begin
            side_reg[0] <= in_side;
            len_reg[0]  <= (in_root == 32'd0) ? 32'd1 : in_root;
            for (int c = 0; c < 3; c++) begin
                neg_reg[0][c] <= m_in[c][31];
                mag_reg[c]    <= m_in[c][31] ? (32'd0 - $unsigned(m_in[c]))
                                             : $unsigned(m_in[c]);
            end
        end
        for (int j = 0; j < QW; j++) begin
            if (en[j+1]) begin
                side_reg[j+1] <= side_reg[j];
                len_reg[j+1]  <= len_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                for (int c = 0; c < 3; c++) begin
                    rem_reg[j][c] <= rem_next[j][c];
                    lo_reg[j][c]  <= lo_next[j][c];
                    q_reg[j][c]   <= q_next[j][c];
                end
            end
        end
        if (en[N-1]) begin
            side_reg[N-1] <= side_reg[N-2];
            for (int c = 0; c < 3; c++) begin
                norm_reg[c] <= neg_reg[N-2][c]
                             ? $signed((QW+1)'(0) - {1'b0, q_reg[QW-1][c]})
                             : $signed({1'b0, q_reg[QW-1][c]});
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_norm  = norm_reg;

endmodule

// File: rtl/gsr_refl.sv
// Velocity reflection about the unit normal: dot product, scale, subtract, saturate.
module gsr_refl
    import gsr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  side_t                       in_side,
    input  logic signed [FRAC_BITS+1:0] in_norm [3],
    output logic                        out_valid,
    input  logic                        out_ready,
    output side_t                       out_side,
    output logic signed [31:0]          out_vel [3]
);

    localparam int NW = FRAC_BITS + 2;
    localparam int PW = 32 + NW;
    localparam int SW = PW + 2;
    localparam int DW = SW - FRAC_BITS;
    localparam int TW = DW + NW;
    localparam int RW = TW - FRAC_BITS + 1;
    localparam int N  = 4;

    logic [N-1:0] valid_reg;
    logic [N-1:0] en;
    side_t        side_reg [N];
    logic signed [NW-1:0] norm_a_reg [3];
    logic signed [NW-1:0] norm_b_reg [3];
    logic signed [PW-1:0] prod_reg [3];
    logic signed [DW-1:0] d_reg;
    logic signed [RW-1:0] r_reg [3];
    logic signed [31:0]   vel_reg [3];
    logic signed [31:0]   vel_in [3];
    logic signed [31:0]   vel_c [3];
    logic signed [SW-1:0] dot_sum;
    logic signed [TW-1:0] t_prod [3];

    always_comb
    begin
        en[N-1] = !valid_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vel_in[0] = in_side.cell_vel_x;
        vel_in[1] = in_side.cell_vel_y;
        vel_in[2] = in_side.cell_vel_z;
        vel_c[0]  = side_reg[2].cell_vel_x;
        vel_c[1]  = side_reg[2].cell_vel_y;
        vel_c[2]  = side_reg[2].cell_vel_z;
        dot_sum   = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);
        for (int c = 0; c < 3; c++) begin
            t_prod[c] = d_reg * norm_b_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            for (int k = 0; k < N; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            side_reg[0] <= in_side;
            for (int c = 0; c < 3; c++) begin
                norm_a_reg[c] <= in_norm[c];
                prod_reg[c]   <= vel_in[c] * in_norm[c];
            end
        end
        // Floor the dot product back to Q format by dropping fraction bits.
        if (en[1]) begin
            side_reg[1] <= side_reg[0];
            norm_b_reg  <= norm_a_reg;
            d_reg       <= dot_sum[SW-1:FRAC_BITS];
        end
        // Twice the scaled normal, floored: one fraction bit fewer dropped.
        if (en[2]) begin
            side_reg[2] <= side_reg[1];
            for (int c = 0; c < 3; c++) begin
                r_reg[c] <= t_prod[c][TW-1:FRAC_BITS-1];
            end
        end
        if (en[3]) begin
            side_reg[3] <= side_reg[2];
            for (int c = 0; c < 3; c++) begin
                vel_reg[c] <= sat32(40'(vel_c[c]) - 40'(r_reg[c]));
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_vel   = vel_reg;

endmodule

// File: rtl/wall_symmetry_ghost_reflect.sv
// Top level: ghost cell boundary condition pipeline with freestream register file.
//
// Usage: one ghost cell request per cycle enters on the s_axis stream. The
// kind code rides in s_axis_tuser; metric, layer and the interior cell's
// primitives ride in s_axis_tdata. The ghost primitives leave on m_axis.
// Wall and 3D symmetry reflect the velocity about the face normal; 2D
// symmetry negates w; extrapolation copies; freestream emits the APB values.
// The path has two square/sum stages and one stage per root bit in the square
// root, one stage per quotient bit plus two in the normal divider, four
// reflection stages and the output register. Throughput is one request per
// cycle while m_axis_tready stays high, as every stage takes a new request
// each clock.
// When m_axis_tready drops, stages stall from the output back; empty stages
// still fill, so the input keeps taking requests until the pipe is full.
// Reset clears every valid bit and loads the freestream defaults (density,
// pressure and temperature 1.0, velocity 0). Write registers only while idle.
module wall_symmetry_ghost_reflect
    import gsr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // lowest bit up: metric_x, metric_y, metric_z, layer, cell_density,
    // cell_vel_x, cell_vel_y, cell_vel_z, cell_pressure, cell_temperature, pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [2:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // lowest bit up: ghost_density, ghost_vel_x, ghost_vel_y, ghost_vel_z,
    // ghost_pressure, ghost_temperature
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic signed [31:0] free_density_reg;
    logic signed [31:0] free_vel_x_reg;
    logic signed [31:0] free_vel_y_reg;
    logic signed [31:0] free_vel_z_reg;
    logic signed [31:0] free_pressure_reg;
    logic signed [31:0] free_temperature_reg;

    side_t in_side;
    logic  sq_valid, sq_ready;
    side_t sq_side;
    logic [31:0] sq_root;
    logic  dv_valid, dv_ready;
    side_t dv_side;
    logic signed [FRAC_BITS+1:0] dv_norm [3];
    logic  rf_valid, rf_ready;
    side_t rf_side;
    logic signed [31:0] rf_vel [3];

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic [2:0]             reg_idx;
    logic                   cfg_wr;

    // Register file: write on the access phase, no wait states.
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            free_density_reg     <= 32'sd65536;
            free_vel_x_reg       <= 32'sd0;
            free_vel_y_reg       <= 32'sd0;
            free_vel_z_reg       <= 32'sd0;
            free_pressure_reg    <= 32'sd65536;
            free_temperature_reg <= 32'sd65536;
        end
        else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FREE_DENSITY:     free_density_reg     <= pwdata;
                REG_FREE_VEL_X:       free_vel_x_reg       <= pwdata;
                REG_FREE_VEL_Y:       free_vel_y_reg       <= pwdata;
                REG_FREE_VEL_Z:       free_vel_z_reg       <= pwdata;
                REG_FREE_PRESSURE:    free_pressure_reg    <= pwdata;
                REG_FREE_TEMPERATURE: free_temperature_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FREE_DENSITY:     prdata = free_density_reg;
            REG_FREE_VEL_X:       prdata = free_vel_x_reg;
            REG_FREE_VEL_Y:       prdata = free_vel_y_reg;
            REG_FREE_VEL_Z:       prdata = free_vel_z_reg;
            REG_FREE_PRESSURE:    prdata = free_pressure_reg;
            REG_FREE_TEMPERATURE: prdata = free_temperature_reg;
            default:              prdata = 32'd0;
        endcase
    end

    // Unpack the request.
    always_comb
    begin
        in_side.kind             = s_axis_tuser;
        in_side.metric_x         = s_axis_tdata[31:0];
        in_side.metric_y         = s_axis_tdata[63:32];
        in_side.metric_z         = s_axis_tdata[95:64];
        in_side.layer            = s_axis_tdata[99:96];
        in_side.cell_density     = s_axis_tdata[131:100];
        in_side.cell_vel_x       = s_axis_tdata[163:132];
        in_side.cell_vel_y       = s_axis_tdata[195:164];
        in_side.cell_vel_z       = s_axis_tdata[227:196];
        in_side.cell_pressure    = s_axis_tdata[259:228];
        in_side.cell_temperature = s_axis_tdata[291:260];
    end

    gsr_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_side   (in_side),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    gsr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_side   (sq_side),
        .in_root   (sq_root),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_side  (dv_side),
        .out_norm  (dv_norm)
    );

    gsr_refl #(.FRAC_BITS(FRAC_BITS)) u_refl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_side   (dv_side),
        .in_norm   (dv_norm),
        .out_valid (rf_valid),
        .out_ready (rf_ready),
        .out_side  (rf_side),
        .out_vel   (rf_vel)
    );

    // Pick the ghost values by boundary kind; unused codes copy the cell.
    always_comb
    begin
        logic signed [31:0] g_rho, g_u, g_v, g_w, g_p, g_t;
        g_rho = rf_side.cell_density;
        g_u   = rf_side.cell_vel_x;
        g_v   = rf_side.cell_vel_y;
        g_w   = rf_side.cell_vel_z;
        g_p   = rf_side.cell_pressure;
        g_t   = rf_side.cell_temperature;
        case (rf_side.kind) inside
            KIND_WALL, KIND_SYM3D:
            begin
                g_u = rf_vel[0];
                g_v = rf_vel[1];
                g_w = rf_vel[2];
                // Wall flips density sign on layer NEG_LAYER.
                if (rf_side.kind == KIND_WALL && rf_side.layer == NEG_LAYER) begin
                    g_rho = sat32(40'sd0 - 40'(rf_side.cell_density));
                end
            end
            KIND_SYM2D:
            begin
                g_w = sat32(40'sd0 - 40'(rf_side.cell_vel_z));
            end
            KIND_FREE:
            begin
                g_rho = free_density_reg;
                g_u   = free_vel_x_reg;
                g_v   = free_vel_y_reg;
                g_w   = free_vel_z_reg;
                g_p   = free_pressure_reg;
                g_t   = free_temperature_reg;
            end
            default: ;
        endcase
        out_data_next = {g_t, g_p, g_w, g_v, g_u, g_rho};
    end

    // Output register: load when empty or when the receiver takes the result.
    assign rf_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (rf_ready) begin
            out_valid_reg <= rf_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_ready) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
